// ===== hw/rtl/bdpc_pkg.sv =====
`default_nettype none
package bdpc_pkg;

  localparam int unsigned BUTTONS = 4;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // input word kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PRESS_TIME  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_code_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_time;
    logic [CNT_W-1:0] min_press_time;
    logic [CNT_W-1:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] raw_pressed;
    logic [1:0] button;
  } item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic [3:0] stable_pressed;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/button_debounce_press_classifier.sv =====
`default_nettype none
// Debouncer and short/long press classifier for four push buttons. Each input
// word is either a one-millisecond tick carrying the pressed levels, or a take
// of one button's latched event; every word yields exactly one result word
// holding the taken event (none on ticks) and the debounced pressed mask after
// that word. One word is accepted per clock: the per-button counters and
// threshold compares sit between the input and the result register, so the
// result appears the cycle after acceptance, and the block only stalls while
// its result register is full and the downstream side is stalling.
// Configuration writes are to be made while no word is in flight.
module button_debounce_press_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire bdpc_pkg::item_t                item,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output bdpc_pkg::result_t                   result,
  input  wire logic                           cfg_we,
  input  wire logic [bdpc_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [bdpc_pkg::CNT_W-1:0]     cfg_wdata
);
  import bdpc_pkg::*;

  cfg_t               cfg;
  logic               accept;
  logic               is_tick;
  logic               is_take;
  logic [BUTTONS-1:0] stable_vec;
  logic [BUTTONS-1:0] stable_next_vec;
  event_code_t        pend [BUTTONS];
  result_t            load_word;
  logic               busy;

  bdpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;
  assign is_tick    = accept && (item.kind == KIND_TICK);
  assign is_take    = accept && (item.kind == KIND_TAKE);

  for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
    bdpc_button u_btn (
      .clk         (clk),
      .rst         (rst),
      .cfg         (cfg),
      .tick        (is_tick),
      .take        (is_take && (item.button == 2'(i))),
      .raw         (item.raw_pressed[i]),
      .stable      (stable_vec[i]),
      .stable_next (stable_next_vec[i]),
      .pend        (pend[i])
    );
  end

  always_comb begin
    load_word.event_code     = is_take ? pend[item.button] : EV_NONE;
    load_word.stable_pressed = stable_next_vec;
  end

  bdpc_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .load_word    (load_word),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.kind == KIND_TAKE)
      |=> pend[$past(item.button)] == EV_NONE)
    else $error("taken event not cleared");

  a_tick_no_event: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.kind == KIND_TICK)
      |=> result_valid && result.event_code == EV_NONE)
    else $error("tick produced an event");

  a_mask_tracks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> result.stable_pressed == stable_vec)
    else $error("result mask differs from debounced state");

endmodule
`default_nettype wire

// ===== hw/rtl/bdpc_cfg_regs.sv =====
`default_nettype none
module bdpc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bdpc_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [bdpc_pkg::CNT_W-1:0]     cfg_wdata,
  output bdpc_pkg::cfg_t                      cfg
);
  import bdpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= CNT_W'(50);
      cfg.min_press_time  <= CNT_W'(50);
      cfg.long_press_time <= CNT_W'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME:   cfg.debounce_time   <= cfg_wdata;
        REG_MIN_PRESS_TIME:  cfg.min_press_time  <= cfg_wdata;
        REG_LONG_PRESS_TIME: cfg.long_press_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bdpc_button.sv =====
`default_nettype none
module bdpc_button (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bdpc_pkg::cfg_t      cfg,
  input  wire logic                tick,
  input  wire logic                take,
  input  wire logic                raw,
  output logic                     stable,
  output logic                     stable_next,
  output bdpc_pkg::event_code_t    pend
);
  import bdpc_pkg::*;

  logic             last_raw, last_raw_next;
  logic [CNT_W-1:0] settle_count, settle_count_next;
  logic [CNT_W-1:0] hold_count, hold_count_next;
  logic             long_fired, long_fired_next;
  event_code_t      pend_next;
  logic [CNT_W-1:0] hold_inc;

  always_comb begin
    last_raw_next     = last_raw;
    settle_count_next = settle_count;
    hold_count_next   = hold_count;
    long_fired_next   = long_fired;
    stable_next       = stable;
    pend_next         = pend;
    hold_inc          = sat_inc(hold_count);
    if (take) begin
      pend_next = EV_NONE;
    end else if (tick) begin
      hold_count_next = hold_inc;
      if (raw != last_raw) begin
        last_raw_next     = raw;
        settle_count_next = '0;
      end else begin
        settle_count_next = sat_inc(settle_count);
      end
      // only a settled level moves the classifier
      if (settle_count_next >= cfg.debounce_time) begin
        if (raw != stable) begin
          stable_next = raw;
          if (raw) begin
            hold_count_next = '0;
            long_fired_next = 1'b0;
          end else begin
            if (!long_fired && hold_inc >= cfg.min_press_time) pend_next = EV_SHORT;
            long_fired_next = 1'b0;
          end
        end
        if (stable_next && !long_fired_next &&
            hold_count_next >= cfg.long_press_time) begin
          long_fired_next = 1'b1;
          pend_next       = EV_LONG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      stable       <= 1'b0;
      settle_count <= '0;
      hold_count   <= '0;
      long_fired   <= 1'b0;
      pend         <= EV_NONE;
    end else begin
      last_raw     <= last_raw_next;
      stable       <= stable_next;
      settle_count <= settle_count_next;
      hold_count   <= hold_count_next;
      long_fired   <= long_fired_next;
      pend         <= pend_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bdpc_out_reg.sv =====
`default_nettype none
module bdpc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire bdpc_pkg::result_t load_word,
  output logic                   busy,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output bdpc_pkg::result_t      result
);
  import bdpc_pkg::*;

  // full and not drained this cycle: hold the upstream side
  assign busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= load_word;
  end

endmodule
`default_nettype wire
